// File: src/crc8fc_pkg.sv
// Shared types, codes and the CRC-8 update for the CRC-8 frame checker.
package crc8fc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef enum logic [2:0] {
        PH_COMMAND = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC     = 3'd3,
        PH_DRAIN   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_MISMATCH  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       verdict_valid;
        status_t    status;
        logic [7:0] command;
        logic [7:0] payload_length;
    } result_t;

    // One byte through CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: src/crc8fc_core.sv
// Frame parser state and per-byte result logic for the CRC-8 frame checker.
module crc8fc_core
    import crc8fc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_buffer,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] left_dec;
    logic [7:0] crc_upd;

    assign left_dec = left_reg - 8'd1;
    assign crc_upd  = crc8_feed(crc_reg, in_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COMMAND;
            cmd_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            crc_reg   <= CRC_INIT;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        case (phase_reg)
            PH_COMMAND:
            begin
                cmd_next  = in_byte;
                len_next  = '0;
                left_next = '0;
                crc_next  = crc8_feed(CRC_INIT, in_byte);
                if (!end_of_buffer)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                len_next  = in_byte;
                left_next = in_byte;
                crc_next  = crc_upd;
                if (end_of_buffer)
                begin
                    phase_next = PH_COMMAND;
                end
                else if (in_byte != 8'd0)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_PAYLOAD:
            begin
                left_next = left_dec;
                crc_next  = crc_upd;
                if (end_of_buffer)
                begin
                    phase_next = PH_COMMAND;
                end
                else if (left_dec == 8'd0)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                phase_next = end_of_buffer ? PH_COMMAND : PH_DRAIN;
            end
            default:
            begin
                if (end_of_buffer)
                begin
                    phase_next = PH_COMMAND;
                end
            end
        endcase
    end

    // per-byte result
    always_comb
    begin
        res = '0;
        res.status = ST_OK;
        case (phase_reg)
            PH_COMMAND:
            begin
                if (end_of_buffer)
                begin
                    res.verdict_valid = 1'b1;
                    res.status        = ST_TRUNCATED;
                    res.command       = in_byte;
                end
            end
            PH_LENGTH:
            begin
                if (end_of_buffer)
                begin
                    res.verdict_valid  = 1'b1;
                    res.status         = ST_TRUNCATED;
                    res.command        = cmd_reg;
                    res.payload_length = in_byte;
                end
            end
            PH_PAYLOAD:
            begin
                res.payload_byte  = in_byte;
                res.payload_valid = 1'b1;
                if (end_of_buffer)
                begin
                    res.verdict_valid  = 1'b1;
                    res.status         = ST_TRUNCATED;
                    res.command        = cmd_reg;
                    res.payload_length = len_reg;
                end
            end
            PH_CRC:
            begin
                res.verdict_valid  = 1'b1;
                res.status         = (in_byte == crc_reg) ? ST_OK : ST_MISMATCH;
                res.command        = cmd_reg;
                res.payload_length = len_reg;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_buffer |=> phase_reg == PH_COMMAND)
        else $error("no rearm after buffer end");

    a_crc_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_CRC |-> res.verdict_valid && !res.payload_valid)
        else $error("CRC byte without verdict");

    a_payload_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_PAYLOAD && !end_of_buffer && left_dec == 8'd0
        |=> phase_reg == PH_CRC)
        else $error("payload run did not end at declared length");

endmodule

// File: src/crc8_frame_checker.sv
// Top level of the CRC-8 frame checker: stream ports and result register.
// Each input transfer's result is registered and shown on the master side in the cycle after the transfer.
// Throughput: one byte per cycle while the master side takes results; the per-byte CRC-8
// update is a single unrolled step between the parser state and the result register.
// The slave side stays ready while the result register is empty or drained.
// Reset (rst_n low, asynchronous) empties the result register and rearms the
// parser to expect a command byte with a zero CRC.
module crc8_frame_checker
    import crc8fc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [15:8] command, [23:16] payload_length
    output logic [3:0]  m_tuser    // [0] payload_valid, [1] verdict_valid, [3:2] status
);

    logic    accept;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    // Result register refills in the same cycle it drains.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    crc8fc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (s_tdata),
        .end_of_buffer (s_tlast),
        .res           (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.payload_length, out_reg.command, out_reg.payload_byte};
    assign m_tuser  = {out_reg.status, out_reg.verdict_valid, out_reg.payload_valid};

    a_quiet_without_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_reg.verdict_valid
        |-> out_reg.status == ST_OK && out_reg.command == 8'd0
            && out_reg.payload_length == 8'd0)
        else $error("verdict fields set without verdict");

    a_quiet_without_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_reg.payload_valid |-> out_reg.payload_byte == 8'd0)
        else $error("payload byte set without payload");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.status == ST_OK || out_reg.status == ST_TRUNCATED
            || out_reg.status == ST_MISMATCH)
        else $error("illegal status code");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("stalled with empty result register");

endmodule

// File: tb/sv/crc8_frame_checker_test.sv
// Self-checking testbench for the CRC-8 frame checker: directed table, then random frames.
`timescale 1ns / 100ps

module crc8_frame_checker_test;
    import crc8fc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 700;
    localparam int QUIET_AFTER   = 600;      // no idling once this many random transfers went in
    localparam int HOLD_AT       = 60;       // transfers in before the long sink hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4;        // slack after the last output transfer; the block output is registered
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SHOW_MAX      = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] in_byte
    logic        s_tlast = 1'b0;      // end_of_buffer
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [7:0] payload_byte, [15:8] command, [23:16] payload_length
    logic [3:0]  m_tuser;             // [0] payload_valid, [1] verdict_valid, [3:2] status

    crc8_frame_checker uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Frame parser prediction: own copy of the parser state.
    // ------------------------------------------------------------------
    phase_t     parse_phase = PH_COMMAND;
    logic [7:0] frame_cmd   = 8'h00;
    logic [7:0] frame_len   = 8'h00;
    logic [7:0] left_cnt    = 8'h00;
    logic [7:0] run_crc     = 8'h00;    // CRC over command, length and payload so far

    result_t pending_results[$];        // one expected output transfer per input transfer

    int  n_sent     = 0;
    int  n_errors   = 0;
    int  n_cycles   = 0;
    bit  quiet      = 1'b0;             // both sides stop idling near the end
    bit  held       = 1'b0;

    // CRC-8, poly x^8+x^2+x+1, shifted in MSB first one data bit at a time.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    function automatic result_t make_result(input logic [7:0] pbyte, input logic pvalid,
                                            input logic vvalid, input status_t st,
                                            input logic [7:0] cmd, input logic [7:0] len);
        result_t r;
        r.payload_byte   = pbyte;
        r.payload_valid  = pvalid;
        r.verdict_valid  = vvalid;
        r.status         = st;
        r.command        = cmd;
        r.payload_length = len;
        return r;
    endfunction

    // Advance the parser by one received byte and return the output it causes.
    task automatic parse_frame_byte(input logic [7:0] b, input logic last, output result_t r);
        logic    vv;
        status_t st;
        r  = '0;
        vv = 1'b0;
        st = ST_OK;
        case (parse_phase)
            PH_COMMAND:
            begin
                frame_cmd = b;
                frame_len = 8'h00;
                left_cnt  = 8'h00;
                run_crc   = crc8_step(8'h00, b);
                if (last)
                begin
                    vv = 1'b1;
                    st = ST_TRUNCATED;
                end
                else
                begin
                    parse_phase = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                frame_len = b;
                left_cnt  = b;
                run_crc   = crc8_step(run_crc, b);
                if (last)
                begin
                    vv = 1'b1;
                    st = ST_TRUNCATED;
                    parse_phase = PH_COMMAND;
                end
                else
                begin
                    // zero length: next byte is already the CRC
                    parse_phase = (b != 8'h00) ? PH_PAYLOAD : PH_CRC;
                end
            end
            PH_PAYLOAD:
            begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                run_crc  = crc8_step(run_crc, b);
                left_cnt = left_cnt - 8'd1;
                if (last)
                begin
                    vv = 1'b1;
                    st = ST_TRUNCATED;
                    parse_phase = PH_COMMAND;
                end
                else if (left_cnt == 8'h00)
                begin
                    parse_phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                vv = 1'b1;
                st = (b == run_crc) ? ST_OK : ST_MISMATCH;
                parse_phase = last ? PH_COMMAND : PH_DRAIN;
            end
            default:
            begin
                // trailing bytes after the CRC are dropped up to the buffer end
                if (last)
                begin
                    parse_phase = PH_COMMAND;
                end
            end
        endcase
        r.verdict_valid = vv;
        if (vv)
        begin
            r.status         = st;
            r.command        = frame_cmd;
            r.payload_length = frame_len;
        end
    endtask

    // ------------------------------------------------------------------
    // Slave-side driver: random gap, then hold the byte until transfer.
    // A fixed expectation replaces the prediction for table rows that carry one.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit fixed, input result_t fixed_exp);
        int      gap;
        result_t predicted;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        parse_frame_byte(b, last, predicted);
        pending_results.push_back(fixed ? fixed_exp : predicted);
        n_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b, input logic last);
        send_byte(b, last, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         use_crc;    // drive the running CRC instead of data
        bit         fixed;
        result_t    exp;
    } row_t;

    row_t table_rows[$];

    task automatic add_row(input logic [7:0] data, input logic last, input bit use_crc,
                           input bit fixed, input result_t exp);
        row_t r;
        r.data    = data;
        r.last    = last;
        r.use_crc = use_crc;
        r.fixed   = fixed;
        r.exp     = exp;
        table_rows.push_back(r);
    endtask

    task automatic build_table();
        // one-byte buffer, right after reset
        add_row(8'hFF, 1'b1, 0, 1, make_result(8'h00, 0, 1, ST_TRUNCATED, 8'hFF, 8'h00));
        // all-zero frame, empty payload, CRC of zeros is zero
        add_row(8'h00, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b1, 0, 1, make_result(8'h00, 0, 1, ST_OK, 8'h00, 8'h00));
        // same frame with a wrong CRC byte
        add_row(8'h00, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b0, 0, 0, '0);
        add_row(8'hFF, 1'b1, 0, 1, make_result(8'h00, 0, 1, ST_MISMATCH, 8'h00, 8'h00));
        // buffer ends on the length byte
        add_row(8'h5A, 1'b0, 0, 0, '0);
        add_row(8'h02, 1'b1, 0, 1, make_result(8'h00, 0, 1, ST_TRUNCATED, 8'h5A, 8'h02));
        // buffer ends inside the payload; the byte still passes through
        add_row(8'h81, 1'b0, 0, 0, '0);
        add_row(8'h03, 1'b0, 0, 0, '0);
        add_row(8'hFF, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b1, 0, 1, make_result(8'h00, 1, 1, ST_TRUNCATED, 8'h81, 8'h03));
        // good CRC before the buffer end, then trailing bytes are dropped
        add_row(8'h3C, 1'b0, 0, 0, '0);
        add_row(8'h01, 1'b0, 0, 0, '0);
        add_row(8'h80, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b0, 1, 0, '0);
        add_row(8'h11, 1'b0, 0, 1, '0);
        add_row(8'h22, 1'b0, 0, 1, '0);
        add_row(8'h33, 1'b1, 0, 1, '0);
        // good CRC on the last byte
        add_row(8'hC3, 1'b0, 0, 0, '0);
        add_row(8'h01, 1'b0, 0, 0, '0);
        add_row(8'h7E, 1'b0, 0, 0, '0);
        add_row(8'h00, 1'b1, 1, 0, '0);
    endtask

    // ------------------------------------------------------------------
    // Random buffers: mostly well-formed frames, some bad CRC, truncation, noise.
    // ------------------------------------------------------------------
    task automatic send_random_buffer(input int frame_no);
        int         kind;
        int         len;
        int         cut;
        int         trail;
        logic [7:0] crc_byte;
        kind = $urandom_range(0, 99);
        if (frame_no == 2)
        begin
            len = 255;
        end
        else if ($urandom_range(0, 59) == 0)
        begin
            len = $urandom_range(9, 255);
        end
        else
        begin
            len = $urandom_range(0, 8);
        end
        if (kind >= 90)
        begin
            // noise: random bytes, flagged end on the final one
            trail = $urandom_range(1, 5);
            for (int i = 0; i < trail; i++)
            begin
                send_plain(8'($urandom_range(0, 255)), i == trail - 1);
            end
        end
        else if (kind >= 75)
        begin
            // truncated: end flag somewhere from the command up to the last payload byte
            cut = $urandom_range(0, len + 1);
            send_plain(8'($urandom_range(0, 255)), cut == 0);
            if (cut > 0)
            begin
                send_plain(len[7:0], cut == 1);
                for (int i = 2; i <= cut; i++)
                begin
                    send_plain(8'($urandom_range(0, 255)), i == cut);
                end
            end
        end
        else
        begin
            send_plain(8'($urandom_range(0, 255)), 1'b0);
            send_plain(len[7:0], 1'b0);
            for (int i = 0; i < len; i++)
            begin
                send_plain(8'($urandom_range(0, 255)), 1'b0);
            end
            trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            crc_byte = run_crc;
            if (kind >= 60)
            begin
                crc_byte = crc_byte ^ 8'($urandom_range(1, 255));
            end
            send_plain(crc_byte, trail == 0);
            for (int i = 0; i < trail; i++)
            begin
                send_plain(8'($urandom_range(0, 255)), i == trail - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Master-side sink: random stalls, one long hold-off to back up the input.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && n_sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker and run-time limit.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.payload_byte   = m_tdata[7:0];
            got.command        = m_tdata[15:8];
            got.payload_length = m_tdata[23:16];
            got.payload_valid  = m_tuser[0];
            got.verdict_valid  = m_tuser[1];
            got.status         = status_t'(m_tuser[3:2]);
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= SHOW_MAX)
                begin
                    $display("unexpected output transfer: tdata=%h tuser=%h", m_tdata, m_tuser);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.payload_byte   !== want.payload_byte  ||
                    got.payload_valid  !== want.payload_valid ||
                    got.verdict_valid  !== want.verdict_valid ||
                    got.status         !== want.status        ||
                    got.command        !== want.command       ||
                    got.payload_length !== want.payload_length)
                begin
                    n_errors++;
                    if (n_errors <= SHOW_MAX)
                    begin
                        $display("mismatch: exp pb=%h pv=%b vv=%b st=%0d cmd=%h len=%h",
                                 want.payload_byte, want.payload_valid, want.verdict_valid,
                                 want.status, want.command, want.payload_length);
                        $display("          got pb=%h pv=%b vv=%b st=%0d cmd=%h len=%h",
                                 got.payload_byte, got.payload_valid, got.verdict_valid,
                                 got.status, got.command, got.payload_length);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int frame_no;
        int random_base;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_table();
        foreach (table_rows[i])
        begin
            send_byte(table_rows[i].use_crc ? run_crc : table_rows[i].data,
                      table_rows[i].last, table_rows[i].fixed, table_rows[i].exp);
        end

        random_base = n_sent;
        frame_no = 0;
        while (n_sent - random_base < RANDOM_ITEMS)
        begin
            if (n_sent - random_base >= QUIET_AFTER)
            begin
                quiet = 1'b1;
            end
            send_random_buffer(frame_no);
            frame_no++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
